### design/hll_sketch_add_unit_assert.svh
// Assertion macros for the sketch add unit.
// Empty bodies when SYNTHESIS is defined.
`ifndef HLL_SKETCH_ADD_UNIT_ASSERT_SVH
`define HLL_SKETCH_ADD_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HSA_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// implication with a delayed consequent
`define HSA_ASSERT_DLY4(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> ##4 (cons)) \
		else $error(msg);

`else

`define HSA_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg)
`define HSA_ASSERT_DLY4(lbl, clk_s, rst_n_s, ante, cons, msg)

`endif

`endif

### design/hsa_pkg.sv
package hsa_pkg;

	// MurmurHash64A constants
	localparam int HASH_W = 64;
	localparam logic [HASH_W-1:0] MUR_M = 64'hc6a4a7935bd1e995;
	localparam int MUR_R = 47;

	// field widths
	localparam int SEED_W = 32;
	localparam logic [SEED_W-1:0] SEED_RESET = 32'hadc83b19;
	localparam int VB_W = 4;
	localparam int LEN_W = 32;
	localparam int CHUNK_BYTES = 8;
	localparam int IDX_OUT_W = 14;
	localparam int RUN_W = 6;

	// trailing-zero search: byte groups over the hash word
	localparam int TZ_GROUP_W = 8;
	localparam int TZ_GROUPS = HASH_W / TZ_GROUP_W;
	localparam int TZ_LOW_W = $clog2(TZ_GROUP_W);
	localparam int TZ_HIGH_W = $clog2(TZ_GROUPS);

	// front/back queue
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		F_IDLE,
		F_LEN,
		F_BLOCK,
		F_K1,
		F_K2,
		F_HMUL,
		F_TAIL,
		F_FINCHK,
		F_FIN,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPD
	} back_state_t;

	typedef enum logic [1:0] {
		MS_LL,
		MS_LH,
		MS_HL
	} mul_step_t;

	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] operand;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] product;
	} mul_rsp_t;

	function automatic logic [HASH_W-1:0] mur_xorshift(input logic [HASH_W-1:0] v);
		return v ^ (v >> MUR_R);
	endfunction

endpackage

### design/hsa_if.sv
// chunk channel
interface hsa_in_if;
	logic                          valid;
	logic                          ready;
	logic [hsa_pkg::HASH_W-1:0]    chunk_data;
	logic [hsa_pkg::VB_W-1:0]      valid_bytes;
	logic                          first_chunk;
	logic                          last_chunk;
	logic [hsa_pkg::LEN_W-1:0]     element_length;

	modport source (
		output valid, chunk_data, valid_bytes, first_chunk, last_chunk, element_length,
		input  ready
	);
	modport sink (
		input  valid, chunk_data, valid_bytes, first_chunk, last_chunk, element_length,
		output ready
	);
endinterface

// result channel
interface hsa_out_if;
	logic                           valid;
	logic                           ready;
	logic [hsa_pkg::IDX_OUT_W-1:0]  sketch_index;
	logic [hsa_pkg::RUN_W-1:0]      run_length;
	logic                           register_raised;

	modport source (
		output valid, sketch_index, run_length, register_raised,
		input  ready
	);
	modport sink (
		input  valid, sketch_index, run_length, register_raised,
		output ready
	);
endinterface

### design/hsa_ram.sv
// simple dual-port RAM, registered read
module hsa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 16384
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/hsa_mul.sv
// 64x64 low-half multiply by MUR_M, one 32x32 partial product per cycle
module hsa_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  hsa_pkg::mul_req_t req,
	output hsa_pkg::mul_rsp_t rsp
);
	import hsa_pkg::*;

	logic              busy_q;
	mul_step_t         step_q;
	logic              done_q;
	logic [HASH_W-1:0] a_q;
	logic [HASH_W-1:0] acc_q;
	logic [31:0]       op_x;
	logic [31:0]       op_y;
	logic [HASH_W-1:0] pp;

	// operand select: lo*lo, lo*hi, hi*lo
	always_comb begin
		op_x = (step_q == MS_HL) ? a_q[63:32] : a_q[31:0];
		op_y = (step_q == MS_LH) ? MUR_M[63:32] : MUR_M[31:0];
		pp = op_x * op_y;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= MS_LL;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= MS_LL;
			end else if (busy_q) begin
				unique case (step_q)
					MS_LL: step_q <= MS_LH;
					MS_LH: step_q <= MS_HL;
					MS_HL: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	// operand and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.operand;
		end
		if (busy_q) begin
			if (step_q == MS_LL) begin
				acc_q <= pp;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + pp[31:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.product = acc_q;

endmodule

### design/hsa_queue.sv
// short FIFO between hash front and register back
module hsa_queue #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty
);
	import hsa_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0] CNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/hsa_front.sv
// hash front: takes chunks, runs MurmurHash64A through the shared multiplier
module hsa_front (
	input  logic                         clk,
	input  logic                         arst_n,
	hsa_in_if.sink                       in_ch,
	input  logic                         cfg_wr_en,
	input  logic [hsa_pkg::SEED_W-1:0]   cfg_wr_data,
	input  logic                         clear_busy,
	output hsa_pkg::mul_req_t            mul_req,
	input  hsa_pkg::mul_rsp_t            mul_rsp,
	output logic                         q_push,
	output logic [hsa_pkg::HASH_W-1:0]   q_data,
	input  logic                         q_full
);
	import hsa_pkg::*;

	front_state_t      state_q;
	front_state_t      state_d;
	logic [SEED_W-1:0] seed_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] data_q;
	logic [VB_W-1:0]   nb_q;
	logic              last_q;
	logic [HASH_W-1:0] fin_q;
	logic              accept;
	logic [VB_W-1:0]   nb_in;
	logic [HASH_W-1:0] tail_data;

	assign in_ch.ready = (state_q == F_IDLE) && !clear_busy;
	assign accept = in_ch.valid && in_ch.ready;
	assign q_data = fin_q;

	// byte count clamp, tail byte mask
	always_comb begin
		nb_in = (in_ch.valid_bytes > VB_W'(CHUNK_BYTES)) ? VB_W'(CHUNK_BYTES)
			: in_ch.valid_bytes;
		for (int b = 0; b < CHUNK_BYTES; b++) begin
			tail_data[8*b +: 8] = (VB_W'(b) < nb_q) ? data_q[8*b +: 8] : 8'h00;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		mul_req.start = 1'b0;
		mul_req.operand = '0;
		q_push = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (in_ch.first_chunk) begin
						mul_req.start = 1'b1;
						mul_req.operand = HASH_W'(in_ch.element_length);
						state_d = F_LEN;
					end else begin
						state_d = F_BLOCK;
					end
				end
			end
			F_LEN: begin
				if (mul_rsp.done) state_d = F_BLOCK;
			end
			F_BLOCK: begin
				if (nb_q == VB_W'(CHUNK_BYTES)) begin
					mul_req.start = 1'b1;
					mul_req.operand = data_q;
					state_d = F_K1;
				end else if (nb_q != '0) begin
					mul_req.start = 1'b1;
					mul_req.operand = acc_q ^ tail_data;
					state_d = F_TAIL;
				end else begin
					state_d = F_FINCHK;
				end
			end
			F_K1: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.operand = mur_xorshift(mul_rsp.product);
					state_d = F_K2;
				end
			end
			F_K2: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.operand = acc_q ^ mul_rsp.product;
					state_d = F_HMUL;
				end
			end
			F_HMUL, F_TAIL: begin
				if (mul_rsp.done) state_d = F_FINCHK;
			end
			F_FINCHK: begin
				if (last_q) begin
					mul_req.start = 1'b1;
					mul_req.operand = mur_xorshift(acc_q);
					state_d = F_FIN;
				end else begin
					state_d = F_IDLE;
				end
			end
			F_FIN: begin
				if (mul_rsp.done) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) begin
					q_push = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// state, seed, running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			seed_q <= SEED_RESET;
			acc_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (accept) begin
				last_q <= in_ch.last_chunk;
			end
			if (mul_rsp.done) begin
				if (state_q == F_LEN) begin
					acc_q <= HASH_W'(seed_q) ^ mul_rsp.product;
				end else if (state_q == F_HMUL || state_q == F_TAIL) begin
					acc_q <= mul_rsp.product;
				end
			end
		end
	end

	// chunk payload and finalized hash
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= in_ch.chunk_data;
			nb_q <= nb_in;
		end
		if (mul_rsp.done && state_q == F_FIN) begin
			fin_q <= mur_xorshift(mul_rsp.product);
		end
	end

endmodule

### design/hsa_back.sv
// register back: clear pass, run length, read-compare-write of the sketch RAM, result
module hsa_back #(
	parameter int INDEX_BITS = 14,
	parameter int REGISTER_WIDTH = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hsa_pkg::HASH_W-1:0]  q_head,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        clear_busy,
	hsa_out_if.source                   out_ch
);
	import hsa_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int REST_TOP = HASH_W - INDEX_BITS;
	localparam logic [REGISTER_WIDTH-1:0] REG_MAX = '1;

	back_state_t               state_q;
	back_state_t               state_d;
	logic [INDEX_BITS-1:0]     clr_q;
	logic [INDEX_BITS-1:0]     idx_s1;
	logic [TZ_GROUPS-1:0]      nz_s1;
	logic [TZ_LOW_W-1:0]       low_s1 [TZ_GROUPS];
	logic [HASH_W-1:0]         rest;
	logic [TZ_GROUPS-1:0]      head_nz;
	logic [TZ_LOW_W-1:0]       head_low [TZ_GROUPS];
	logic [RUN_W-1:0]          tz;
	logic [RUN_W-1:0]          run;
	logic [REGISTER_WIDTH-1:0] run_ext;
	logic [REGISTER_WIDTH-1:0] run_sat;
	logic                      raised;
	logic                      out_load;
	logic                      out_valid_q;
	logic [IDX_OUT_W-1:0]      out_idx_q;
	logic [RUN_W-1:0]          out_run_q;
	logic                      out_raised_q;
	logic                      ram_we;
	logic [INDEX_BITS-1:0]     ram_waddr;
	logic [REGISTER_WIDTH-1:0] ram_wdata;
	logic [REGISTER_WIDTH-1:0] ram_rdata;

	hsa_ram #(
		.WIDTH (REGISTER_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_head[INDEX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// per-byte trailing zero count of the bits above the index, sentinel set
	always_comb begin
		rest = (q_head >> INDEX_BITS) | (HASH_W'(1) << REST_TOP);
		for (int g = 0; g < TZ_GROUPS; g++) begin
			head_nz[g] = |rest[TZ_GROUP_W*g +: TZ_GROUP_W];
			head_low[g] = '0;
			for (int b = TZ_GROUP_W - 1; b >= 0; b--) begin
				if (rest[TZ_GROUP_W*g + b]) head_low[g] = TZ_LOW_W'(b);
			end
		end
	end

	// lowest nonzero group gives the run, then saturate and compare
	always_comb begin
		tz = '0;
		for (int g = TZ_GROUPS - 1; g >= 0; g--) begin
			if (nz_s1[g]) tz = {TZ_HIGH_W'(g), low_s1[g]};
		end
		run = tz + 1'b1;
		run_ext = REGISTER_WIDTH'(run);
		run_sat = (run_ext > REG_MAX) ? REG_MAX : run_ext;
		raised = (run_sat > ram_rdata);
	end

	// clear pass, pop, update
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		ram_we = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		out_load = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == '1) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (!q_empty && (!out_valid_q || out_ch.ready)) begin
					q_pop = 1'b1;
					state_d = BK_UPD;
				end
			end
			BK_UPD: begin
				ram_we = raised;
				ram_waddr = idx_s1;
				ram_wdata = run_sat;
				out_load = 1'b1;
				state_d = BK_IDLE;
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	assign clear_busy = (state_q == BK_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// popped item and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			idx_s1 <= q_head[INDEX_BITS-1:0];
			nz_s1 <= head_nz;
			low_s1 <= head_low;
		end
		if (out_load) begin
			out_idx_q <= IDX_OUT_W'(idx_s1);
			out_run_q <= run_sat[RUN_W-1:0];
			out_raised_q <= raised;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.sketch_index = out_idx_q;
	assign out_ch.run_length = out_run_q;
	assign out_ch.register_raised = out_raised_q;

endmodule

### design/hll_sketch_add_unit.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   chunk_data, valid_bytes, first_chunk, last_chunk, element_length
// out_ch    out  valid/ready   sketch_index, run_length, register_raised
// cfg       in   cfg_wr_en     cfg_wr_data (hash seed)
//
// A full 8-byte chunk keeps in_ch.ready low through three multiplies in the shared 32x32
// unit, a 1..7 byte tail through one, an empty chunk through none.
// A first chunk adds the length multiply, a last chunk the finalize multiply and queue push.
// The back part handles one result at a time: RAM read on pop, then compare and write.
// After reset a clearing pass over all 2^INDEX_BITS sketch registers holds in_ch.ready low.
// A stalled out_ch holds one result, two more wait in the queue, one in the front.
`include "hll_sketch_add_unit_assert.svh"

module hll_sketch_add_unit #(
	parameter int INDEX_BITS = 14,
	parameter int REGISTER_WIDTH = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hsa_in_if.sink                      in_ch,
	hsa_out_if.source                   out_ch,
	input  logic                        cfg_wr_en,
	input  logic [hsa_pkg::SEED_W-1:0]  cfg_wr_data
);
	import hsa_pkg::*;

	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;
	logic              q_push;
	logic [HASH_W-1:0] q_data;
	logic              q_full;
	logic              q_pop;
	logic [HASH_W-1:0] q_head;
	logic              q_empty;
	logic              clear_busy;

	hsa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.clear_busy  (clear_busy),
		.mul_req     (mul_req),
		.mul_rsp     (mul_rsp),
		.q_push      (q_push),
		.q_data      (q_data),
		.q_full      (q_full)
	);

	hsa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	hsa_queue #(
		.WIDTH (HASH_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	hsa_back #(
		.INDEX_BITS     (INDEX_BITS),
		.REGISTER_WIDTH (REGISTER_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (q_head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.clear_busy (clear_busy),
		.out_ch     (out_ch)
	);

	// no item is taken while the sketch RAM is being cleared
	`HSA_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, in_ch.ready, !clear_busy, "ready during clear")
	// the front only pushes into a queue with room
	`HSA_ASSERT_IMP(a_push_not_full, clk, arst_n, q_push, !q_full, "push into full queue")
	// the back pops only with an entry present and the output stage free
	`HSA_ASSERT_IMP(a_pop_ok, clk, arst_n, q_pop, !q_empty && (!out_ch.valid || out_ch.ready), "bad pop")
	// every multiply start is followed by its done strobe
	`HSA_ASSERT_DLY4(a_mul_latency, clk, arst_n, mul_req.start, mul_rsp.done, "multiply latency")

endmodule

### test/tb_hll_sketch_add_unit.sv
`timescale 1ns / 100ps

module tb_hll_sketch_add_unit;
	import hsa_pkg::*;

	localparam int IDX_BITS = IDX_OUT_W;
	localparam int REG_COUNT = 1 << IDX_BITS;
	localparam int REG_MAX = (1 << RUN_W) - 1;
	localparam int SETTLE_CYCLES = 64;  // covers the slowest chunk with no result
	localparam int PHASE_ITEMS = 320;

	// one chunk of an element, with an optional typed-in result
	typedef struct packed {
		logic [HASH_W-1:0] data;
		logic [VB_W-1:0]   nb;
		logic              first;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic              pinned;
		logic [IDX_OUT_W-1:0] p_idx;
		logic [RUN_W-1:0]  p_run;
		logic              p_raised;
	} chunk_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] idx;
		logic [RUN_W-1:0]     run;
		logic                 raised;
	} update_t;

	// element kept for re-insertion
	typedef struct {
		int unsigned       nbytes;
		logic [HASH_W-1:0] words [8];
	} elem_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [SEED_W-1:0] cfg_wr_data;

	hsa_in_if  in_ch();
	hsa_out_if out_ch();

	hll_sketch_add_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predictor state
	logic [SEED_W-1:0] seed_now;
	logic [HASH_W-1:0] hash_acc;
	logic [RUN_W-1:0]  sketch_regs [REG_COUNT];
	update_t           pending_updates [$];
	elem_t             recent_elems [$];

	int src_gap_pct;
	int snk_stall_pct;
	int chunks_sent;
	int updates_seen;
	int raised_seen;
	int fail_count;

	// directed chunks; the first two after reset are typed in: a zero hash
	// lands in register 0 with the longest possible run
	chunk_t directed_rows [23] = '{
		'{64'h0, 4'd0, 1'b0, 1'b1, 32'd0, 1'b1, 14'd0, 6'd51, 1'b1},
		'{64'h0, 4'd0, 1'b0, 1'b1, 32'd0, 1'b1, 14'd0, 6'd51, 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h0, 4'd8, 1'b1, 1'b1, 32'd0, 1'b0, 14'd0, 6'd0, 1'b0},
		// too many bytes, longest length
		'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h0123_4567_89AB_CDEF, 4'd9, 1'b1, 1'b1, 32'd8, 1'b0, 14'd0, 6'd0, 1'b0},
		// unused bytes ignored: both give the same update, second not raised
		'{64'hFFFF_FFFF_FFFF_FF5A, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h0000_0000_0000_005A, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'hA5A5_5A5A_C3C3_3C3C, 4'd7, 1'b1, 1'b1, 32'd7, 1'b0, 14'd0, 6'd0, 1'b0},
		// three-chunk element
		'{64'h1111_2222_3333_4444, 4'd8, 1'b1, 1'b0, 32'd19, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h5555_6666_7777_8888, 4'd8, 1'b0, 1'b0, 32'd19, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h9999_AAAA_BBBB_CCCC, 4'd3, 1'b0, 1'b1, 32'd19, 1'b0, 14'd0, 6'd0, 1'b0},
		// short chunk that is not last, then a full one
		'{64'h0000_0000_00AB_CDEF, 4'd3, 1'b1, 1'b0, 32'd11, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'hFEDC_BA98_7654_3210, 4'd8, 1'b0, 1'b1, 32'd11, 1'b0, 14'd0, 6'd0, 1'b0},
		// empty chunk in the middle
		'{64'hDEAD_BEEF_0BAD_F00D, 4'd8, 1'b1, 1'b0, 32'd16, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'hFFFF_0000_FFFF_0000, 4'd0, 1'b0, 1'b0, 32'd16, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b1, 32'd16, 1'b0, 14'd0, 6'd0, 1'b0},
		// length that does not match the bytes
		'{64'h0F0F_0F0F_F0F0_F0F0, 4'd8, 1'b1, 1'b1, 32'd1000, 1'b0, 14'd0, 6'd0, 1'b0},
		// no first chunk after a finished element
		'{64'h7654_3210_0123_4567, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, 14'd0, 6'd0, 1'b0},
		// chunk with neither flag, then a restart
		'{64'h3C3C_3C3C_3C3C_3C3C, 4'd8, 1'b0, 1'b0, 32'd0, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h0000_00AA_BBCC_DDEE, 4'd5, 1'b1, 1'b0, 32'd5, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h0000_0000_1234_5678, 4'd4, 1'b1, 1'b1, 32'd4, 1'b0, 14'd0, 6'd0, 1'b0},
		'{64'h0, 4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 14'd0, 6'd0, 1'b0}
	};

	// one MurmurHash64A block round
	function automatic logic [HASH_W-1:0] murmur_block(input logic [HASH_W-1:0] h,
			input logic [HASH_W-1:0] k);
		logic [HASH_W-1:0] kk;
		logic [HASH_W-1:0] hh;
		kk = k * MUR_M;
		kk = kk ^ (kk >> MUR_R);
		kk = kk * MUR_M;
		hh = (h ^ kk) * MUR_M;
		return hh;
	endfunction

	function automatic logic [HASH_W-1:0] murmur_final(input logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] hh;
		hh = h ^ (h >> MUR_R);
		hh = hh * MUR_M;
		hh = hh ^ (hh >> MUR_R);
		return hh;
	endfunction

	// fold an accepted chunk into the hash; on a last chunk update the sketch
	task automatic absorb_chunk(input chunk_t c);
		int unsigned nb;
		int unsigned run;
		logic [HASH_W-1:0] h;
		logic [HASH_W-1:0] rest;
		logic [HASH_W-1:0] mask;
		logic [IDX_BITS-1:0] idx;
		update_t u;
		nb = (c.nb > CHUNK_BYTES) ? CHUNK_BYTES : c.nb;
		if (c.first) begin
			hash_acc = {32'd0, seed_now} ^ ({32'd0, c.len} * MUR_M);
		end
		if (nb == CHUNK_BYTES) begin
			hash_acc = murmur_block(hash_acc, c.data);
		end else if (nb != 0) begin
			mask = (64'd1 << (8 * nb)) - 64'd1;
			hash_acc = (hash_acc ^ (c.data & mask)) * MUR_M;
		end
		if (!c.last)
			return;
		h = murmur_final(hash_acc);
		idx = h[IDX_BITS-1:0];
		rest = (h >> IDX_BITS) | (64'd1 << (HASH_W - IDX_BITS));
		run = 1;
		while (rest[0] == 1'b0) begin
			rest = rest >> 1;
			run++;
		end
		if (run > REG_MAX)
			run = REG_MAX;
		u.idx = idx;
		u.run = run[RUN_W-1:0];
		u.raised = 1'b0;
		if (run > sketch_regs[idx]) begin
			sketch_regs[idx] = run[RUN_W-1:0];
			u.raised = 1'b1;
		end
		if (c.pinned) begin
			u.idx = c.p_idx;
			u.run = c.p_run;
			u.raised = c.p_raised;
		end
		pending_updates.push_back(u);
	endtask

	// drive one chunk at the falling edge, wait for acceptance
	task automatic send_chunk(input chunk_t c);
		while ($urandom_range(99) < src_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.chunk_data     <= c.data;
		in_ch.valid_bytes    <= c.nb;
		in_ch.first_chunk    <= c.first;
		in_ch.last_chunk     <= c.last;
		in_ch.element_length <= c.len;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		absorb_chunk(c);
		chunks_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every update is back
	task automatic drain_updates();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_updates.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_seed(input logic [SEED_W-1:0] seed);
		drain_updates();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= seed;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		seed_now = seed;
	endtask

	task automatic send_element(input elem_t e, input logic [LEN_W-1:0] len_field);
		int unsigned n;
		int unsigned left;
		chunk_t c;
		n = (e.nbytes == 0) ? 1 : (e.nbytes + 7) / 8;
		left = e.nbytes;
		for (int i = 0; i < n; i++) begin
			c = '0;
			c.data = e.words[i];
			c.nb = VB_W'((left > CHUNK_BYTES) ? CHUNK_BYTES : left);
			left -= c.nb;
			c.first = (i == 0);
			c.last = (i == n - 1);
			c.len = len_field;
			send_chunk(c);
		end
	endtask

	// mostly well-formed elements, some repeats, some noise chunks
	task automatic run_random(input int target);
		int start_count;
		int roll;
		elem_t e;
		chunk_t c;
		start_count = chunks_sent;
		while (chunks_sent - start_count < target) begin
			roll = $urandom_range(99);
			if (roll < 10) begin
				c = '0;
				c.data = {$urandom, $urandom};
				c.nb = VB_W'($urandom_range(15));
				c.first = 1'($urandom_range(1));
				c.last = 1'($urandom_range(1));
				c.len = $urandom;
				send_chunk(c);
			end else if (roll < 30 && recent_elems.size() != 0) begin
				e = recent_elems[$urandom_range(recent_elems.size() - 1)];
				send_element(e, e.nbytes);
			end else begin
				e.nbytes = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(24);
				foreach (e.words[i])
					e.words[i] = {$urandom, $urandom};
				recent_elems.push_back(e);
				if (recent_elems.size() > 32)
					void'(recent_elems.pop_front());
				if ($urandom_range(19) == 0)
					send_element(e, $urandom);
				else
					send_element(e, e.nbytes);
			end
			if ($urandom_range(99) == 0)
				drain_updates();
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// compare each result with the oldest expected update
	always @(posedge clk) begin : check_results
		update_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_updates.size() == 0) begin
				$error("unexpected result: index %0d run %0d raised %0d",
					out_ch.sketch_index, out_ch.run_length, out_ch.register_raised);
				fail_count++;
			end else begin
				want = pending_updates.pop_front();
				updates_seen++;
				if (out_ch.register_raised === 1'b1)
					raised_seen++;
				if (out_ch.sketch_index !== want.idx) begin
					$error("sketch_index: expected %0d, actual %0d",
						want.idx, out_ch.sketch_index);
					fail_count++;
				end
				if (out_ch.run_length !== want.run) begin
					$error("run_length: expected %0d, actual %0d",
						want.run, out_ch.run_length);
					fail_count++;
				end
				if (out_ch.register_raised !== want.raised) begin
					$error("register_raised: expected %0d, actual %0d",
						want.raised, out_ch.register_raised);
					fail_count++;
				end
			end
		end
	end

	// run limit, far above the slowest correct run incl. the RAM clear
	initial begin
		#6_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [SEED_W-1:0] phase_seed [4];
		int phase_src [4];
		int phase_snk [4];
		phase_seed = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, SEED_RESET};
		phase_src = '{30, 47, 0, 0};
		phase_snk = '{47, 30, 0, 0};

		in_ch.valid = 1'b0;
		in_ch.chunk_data = '0;
		in_ch.valid_bytes = '0;
		in_ch.first_chunk = 1'b0;
		in_ch.last_chunk = 1'b0;
		in_ch.element_length = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		src_gap_pct = 30;
		snk_stall_pct = 47;
		chunks_sent = 0;
		updates_seen = 0;
		raised_seen = 0;
		fail_count = 0;
		seed_now = SEED_RESET;
		hash_acc = '0;
		foreach (sketch_regs[i])
			sketch_regs[i] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed chunks under the reset seed
		foreach (directed_rows[i])
			send_chunk(directed_rows[i]);

		// random phases, each under its own seed; only the first two idle the source and stall the sink
		for (int ph = 0; ph < 4; ph++) begin
			src_gap_pct = phase_src[ph];
			snk_stall_pct = phase_snk[ph];
			write_seed(phase_seed[ph]);
			run_random(PHASE_ITEMS);
		end

		drain_updates();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_updates.size() != 0) begin
			$error("%0d expected updates never arrived", pending_updates.size());
			fail_count++;
		end

		$display("%0d chunks sent, %0d sketch updates checked, %0d of them raised a register",
			chunks_sent, updates_seen, raised_seen);
		$display("seeds covered: reset value, all zeros, all ones, one random value");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/hsa_pkg.sv
design/hsa_if.sv
design/hsa_ram.sv
design/hsa_mul.sv
design/hsa_queue.sv
design/hsa_front.sv
design/hsa_back.sv
design/hll_sketch_add_unit.sv
test/tb_hll_sketch_add_unit.sv
